// ===== hdl/isd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// isd_pkg: shared types and constants of the descending insertion sorter
// Holds the list capacity, the word width, the sequencer states and the
// control struct that the top level drives into every cell of the chain.
// ----------------------------------------------------------------------------
package isd_pkg;

    localparam int MAX_ELEMENTS = 16;
    localparam int WORD_W       = 32;

    typedef logic signed [WORD_W-1:0] word_t;

    typedef enum logic {
        ST_FILL,
        ST_DRAIN
    } state_t;

    // Broadcast to all cells: insert a new key, or shift the list toward the head.
    typedef struct packed {
        logic insert;
        logic shift;
    } isd_ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/isd_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// isd_if: request channels of the descending insertion sorter
// One interface for incoming elements and one for sorted results, each with
// a valid/ready handshake and a source and a sink modport.
// ----------------------------------------------------------------------------
interface isd_in_if;
    logic                valid;
    logic                ready;
    isd_pkg::word_t      value;
    logic                last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

interface isd_out_if;
    logic                valid;
    logic                ready;
    isd_pkg::word_t      sorted_value;
    logic                is_last;
    logic                overflow;

    modport source (output valid, output sorted_value, output is_last, output overflow,
                    input ready);
    modport sink   (input valid, input sorted_value, input is_last, input overflow,
                    output ready);
endinterface

`default_nettype wire

// ===== hdl/insertion_sort_descending_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// insertion_sort_descending_unit: stable descending insertion sorter
// Inserts one signed element per request into a chain of cells kept in
// descending order, then drains the whole batch largest first.
// ----------------------------------------------------------------------------
//  Channel   Role   Payload
//  items     sink   value (32, signed), last
//  results   source sorted_value (32, signed), is_last, overflow
//
//  On an element request every cell compares the key at once.
//  After the request flagged last, the list drains from the head cell at one
//  result per cycle while results.ready is high; items.ready is low meanwhile.
//  A request dropped for lack of room is still accepted and sets overflow.
//  Reset clears the cell valid bits, the overflow flag and the sequencer.
//  A stall on results simply holds the head cell in place.
// ----------------------------------------------------------------------------
module insertion_sort_descending_unit (
    input  wire logic  clk,
    input  wire logic  rst_n,
    isd_in_if.sink     items,
    isd_out_if.source  results
);

    localparam int N = isd_pkg::MAX_ELEMENTS;

    isd_pkg::state_t    state_reg;
    isd_pkg::state_t    state_next;
    logic               dropped_reg;
    logic               dropped_next;
    isd_pkg::isd_ctrl_t ctrl;

    isd_pkg::word_t     cell_value [N];
    logic [N-1:0]       cell_valid;
    logic [N-1:0]       cell_ins;

    logic               item_acc;
    logic               result_acc;
    logic               full;

    assign full       = cell_valid[N-1];
    assign item_acc   = items.valid && items.ready;
    assign result_acc = results.valid && results.ready;

    genvar gi;
    generate
        for (gi = 0; gi < N; gi++)
        begin : g_cell
            isd_pkg::word_t pv;
            logic           pvld;
            logic           pins;
            isd_pkg::word_t nv;
            logic           nvld;

            if (gi == 0)
            begin : g_head
                assign pv   = items.value;
                assign pvld = 1'b1;
                assign pins = 1'b0;
            end
            else
            begin : g_body
                assign pv   = cell_value[gi-1];
                assign pvld = cell_valid[gi-1];
                assign pins = cell_ins[gi-1];
            end

            if (gi == N-1)
            begin : g_tail
                assign nv   = cell_value[gi];
                assign nvld = 1'b0;
            end
            else
            begin : g_inner
                assign nv   = cell_value[gi+1];
                assign nvld = cell_valid[gi+1];
            end

            isd_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .key        (items.value),
                .prev_value (pv),
                .prev_valid (pvld),
                .prev_ins   (pins),
                .next_value (nv),
                .next_valid (nvld),
                .value      (cell_value[gi]),
                .valid      (cell_valid[gi]),
                .ins        (cell_ins[gi])
            );
        end
    endgenerate

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            isd_pkg::ST_FILL:
            begin
                if (item_acc && items.last)
                begin
                    state_next = isd_pkg::ST_DRAIN;
                end
            end
            isd_pkg::ST_DRAIN:
            begin
                if (result_acc && !cell_valid[1])
                begin
                    state_next = isd_pkg::ST_FILL;
                end
            end
            default:
            begin
                state_next = isd_pkg::ST_FILL;
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        items.ready   = 1'b0;
        results.valid = 1'b0;
        unique case (state_reg)
            isd_pkg::ST_FILL:
            begin
                items.ready = 1'b1;
            end
            isd_pkg::ST_DRAIN:
            begin
                results.valid = 1'b1;
            end
            default:
            begin
                items.ready   = 1'b0;
                results.valid = 1'b0;
            end
        endcase
    end

    assign ctrl.insert = item_acc && !full;
    assign ctrl.shift  = result_acc;

    assign results.sorted_value = cell_value[0];
    assign results.is_last      = !cell_valid[1];
    assign results.overflow     = dropped_reg;

    always_comb
    begin
        dropped_next = dropped_reg;
        if (item_acc && full)
        begin
            dropped_next = 1'b1;
        end
        else if (result_acc && results.is_last)
        begin
            dropped_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= isd_pkg::ST_FILL;
            dropped_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            dropped_reg <= dropped_next;
        end
    end

    // Checks on the chain contents and the overflow flag.
    logic [N-2:0] order_bad;
    logic [N-2:0] gap_bad;

    always_comb
    begin
        for (int k = 0; k < N-1; k++)
        begin
            order_bad[k] = cell_valid[k+1] && (cell_value[k] < cell_value[k+1]);
            gap_bad[k]   = cell_valid[k+1] && !cell_valid[k];
        end
    end

    a_sorted_order: assert property (@(posedge clk) disable iff (!rst_n)
        !(|order_bad))
        else $error("chain entries out of descending order");

    a_no_gaps: assert property (@(posedge clk) disable iff (!rst_n)
        !(|gap_bad))
        else $error("valid cells are not contiguous from the head");

    a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |-> cell_valid[0])
        else $error("result offered from an empty chain");

    a_empty_after_batch: assert property (@(posedge clk) disable iff (!rst_n)
        (result_acc && results.is_last) |=> (!cell_valid[0] && !dropped_reg))
        else $error("chain or overflow flag not cleared after the final result");

endmodule

`default_nettype wire

// ===== hdl/isd_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// isd_cell: one slot of the insertion chain
// Holds one list entry. On insert it keeps its entry, takes the new key, or
// takes its upper neighbor's entry; on shift it takes its lower neighbor's.
// ----------------------------------------------------------------------------
module isd_cell (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire isd_pkg::isd_ctrl_t ctrl,
    input  wire isd_pkg::word_t     key,
    input  wire isd_pkg::word_t     prev_value,
    input  wire logic               prev_valid,
    input  wire logic               prev_ins,
    input  wire isd_pkg::word_t     next_value,
    input  wire logic               next_valid,
    output isd_pkg::word_t          value,
    output logic                    valid,
    output logic                    ins
);

    isd_pkg::word_t value_reg;
    isd_pkg::word_t value_next;
    logic           valid_reg;
    logic           valid_next;

    // Strict compare keeps equal keys behind the ones already stored.
    assign ins = !valid_reg || (key > value_reg);

    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (ctrl.insert)
        begin
            if (ins)
            begin
                value_next = prev_ins ? prev_value : key;
            end
            valid_next = valid_reg || prev_valid;
        end
        else if (ctrl.shift)
        begin
            value_next = next_value;
            valid_next = next_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign valid = valid_reg;

endmodule

`default_nettype wire

// ===== tb/isd_order_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isd_order_checker: result checker for the descending insertion sorter
// Watches the element and result channels, keeps its own copy of the sorted
// list, queues the results that each closing request must produce and
// compares every accepted result against the oldest one still waiting.
// ----------------------------------------------------------------------------
module isd_order_checker (
    input  wire logic clk,
    input  wire logic rst_n,
    isd_in_if         items,
    isd_out_if        results,
    output int        fail_count,
    output int        pending
);

    typedef struct {
        isd_pkg::word_t value;
        logic           is_last;
        logic           overflow;
    } sorted_result_t;

    isd_pkg::word_t list_words [isd_pkg::MAX_ELEMENTS];
    int             list_len;
    logic           list_dropped;
    int             mismatches;
    sorted_result_t expected_sorted [$];

    // Stable insertion: the new key goes after every stored word that is not
    // smaller, so equal values leave in arrival order.
    task automatic take_element(input isd_pkg::word_t key, input logic closing);
        int             pos;
        int             i;
        sorted_result_t res;
        if (list_len < isd_pkg::MAX_ELEMENTS)
        begin
            pos = list_len;
            while (pos > 0 && list_words[pos-1] < key)
            begin
                list_words[pos] = list_words[pos-1];
                pos--;
            end
            list_words[pos] = key;
            list_len++;
        end
        else
        begin
            list_dropped = 1'b1;
        end
        if (closing)
        begin
            for (i = 0; i < list_len; i++)
            begin
                res.value    = list_words[i];
                res.is_last  = (i == list_len - 1);
                res.overflow = list_dropped;
                expected_sorted.push_back(res);
            end
            list_len     = 0;
            list_dropped = 1'b0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        sorted_result_t head;
        if (!rst_n)
        begin
            expected_sorted.delete();
            list_len     = 0;
            list_dropped = 1'b0;
            mismatches   = 0;
            fail_count  <= 0;
            pending     <= 0;
        end
        else
        begin
            // Elements first, so that a result of the batch closing at this
            // edge would still find its expectation queued.
            if (items.valid && items.ready)
                take_element(items.value, items.last);
            if (results.valid && results.ready)
            begin
                if (expected_sorted.size() == 0)
                begin
                    $error("result with nothing expected: sorted_value %0d",
                           results.sorted_value);
                    mismatches++;
                end
                else
                begin
                    head = expected_sorted.pop_front();
                    if (results.sorted_value !== head.value)
                    begin
                        $error("sorted_value: expected %0d, got %0d",
                               head.value, results.sorted_value);
                        mismatches++;
                    end
                    if (results.is_last !== head.is_last)
                    begin
                        $error("is_last: expected %0b, got %0b",
                               head.is_last, results.is_last);
                        mismatches++;
                    end
                    if (results.overflow !== head.overflow)
                    begin
                        $error("overflow: expected %0b, got %0b",
                               head.overflow, results.overflow);
                        mismatches++;
                    end
                end
            end
            pending    <= expected_sorted.size();
            fail_count <= mismatches;
        end
    end

endmodule

// ===== tb/insertion_sort_descending_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// insertion_sort_descending_unit_tb: testbench of the descending sorter
// Sends directed batches (extremes, duplicates, a batch past capacity) and
// then random batches of mixed length with random idling on both channels,
// one long result stall and one drain pause; the checker judges the results.
// ----------------------------------------------------------------------------
module insertion_sort_descending_unit_tb;

    localparam int RANDOM_ITEMS = 480;
    localparam int LONG_HOLD    = 300;
    localparam int CYCLE_LIMIT  = 400000;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   idle_pct;
    int   hold_requests;
    int   holds_done;
    int   sink_wait;
    int   items_sent;
    int   cycle_count = 0;

    isd_in_if  items ();
    isd_out_if results ();

    insertion_sort_descending_unit i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items),
        .results (results)
    );

    isd_order_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .items      (items),
        .results    (results),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Result side: a running random wait ends first; a requested long hold then takes priority over new random bursts.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            results.ready <= 1'b0;
            sink_wait     <= 0;
            holds_done    <= 0;
        end
        else if (sink_wait != 0)
        begin
            results.ready <= 1'b0;
            sink_wait     <= sink_wait - 1;
        end
        else if (holds_done != hold_requests)
        begin
            results.ready <= 1'b0;
            sink_wait     <= LONG_HOLD;
            holds_done    <= holds_done + 1;
        end
        else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            results.ready <= 1'b0;
            sink_wait     <= $urandom_range(0, 6);
        end
        else
        begin
            results.ready <= 1'b1;
        end
    end

    // Returns at the edge where the element request is accepted, valid still high.
    task automatic send_element(input isd_pkg::word_t v, input logic closing);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            items.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        items.valid <= 1'b1;
        items.value <= v;
        items.last  <= closing;
        @(posedge clk);
        while (!items.ready)
            @(posedge clk);
        items_sent++;
    endtask

    // Small values give many duplicates; the rest spread over the full range.
    function automatic isd_pkg::word_t random_element();
        isd_pkg::word_t v;
        case ($urandom_range(0, 5))
            0, 1:    v = isd_pkg::word_t'(int'($urandom_range(0, 8)) - 4);
            2:
            begin
                case ($urandom_range(0, 3))
                    0:       v = 32'sh7FFF_FFFF;
                    1:       v = 32'sh8000_0000;
                    2:       v = '0;
                    default: v = -32'sd1;
                endcase
            end
            default: v = isd_pkg::word_t'($urandom);
        endcase
        return v;
    endfunction

    task automatic send_batch(input int len);
        int i;
        for (i = 0; i < len; i++)
            send_element(random_element(), i == len - 1);
    endtask

    task automatic wait_drained();
        items.valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        @(posedge clk);
    endtask

    function automatic int random_batch_len();
        int len;
        case ($urandom_range(0, 9))
            0:       len = isd_pkg::MAX_ELEMENTS + $urandom_range(1, 6);
            1:       len = isd_pkg::MAX_ELEMENTS;
            2, 3:    len = $urandom_range(1, 3);
            default: len = $urandom_range(1, isd_pkg::MAX_ELEMENTS - 1);
        endcase
        return len;
    endfunction

    initial
    begin : stimulus
        int i;
        bit hold_issued;
        bit pause_issued;
        hold_issued   = 1'b0;
        pause_issued  = 1'b0;
        items_sent    = 0;
        rst_n        <= 1'b0;
        items.valid  <= 1'b0;
        items.value  <= '0;
        items.last   <= 1'b0;
        idle_pct     <= 20;
        hold_requests <= 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A batch of one element closed by itself.
        send_element('0, 1'b1);

        // Extremes, sign boundaries and a duplicate pair.
        send_element(32'sh7FFF_FFFF, 1'b0);
        send_element(32'sh8000_0000, 1'b0);
        send_element(-32'sd1, 1'b0);
        send_element('0, 1'b0);
        send_element(32'sd1, 1'b0);
        send_element(32'sd1, 1'b0);
        send_element(-32'sd2, 1'b1);

        // One past capacity: the closing element itself is dropped.
        for (i = 0; i <= isd_pkg::MAX_ELEMENTS; i++)
            send_element(isd_pkg::word_t'((i % 5) * 13 - 20),
                         i == isd_pkg::MAX_ELEMENTS);

        while (items_sent < RANDOM_ITEMS)
        begin
            if (items_sent > RANDOM_ITEMS - 80)
                idle_pct <= 0;
            else
            begin
                case ($urandom_range(0, 3))
                    0:       idle_pct <= 0;
                    1:       idle_pct <= 10;
                    default: idle_pct <= 30;
                endcase
            end

            if (!hold_issued && items_sent >= 150)
            begin
                // The results stall while a full batch and the next one arrive,
                // so the sorter fills up and stops taking elements.
                hold_issued    = 1'b1;
                hold_requests <= hold_requests + 1;
                send_batch(isd_pkg::MAX_ELEMENTS);
                send_batch(3);
            end
            else if (!pause_issued && items_sent >= 300)
            begin
                pause_issued = 1'b1;
                wait_drained();
                send_batch(random_batch_len());
            end
            else
            begin
                send_batch(random_batch_len());
            end
        end

        wait_drained();
        repeat (2 * isd_pkg::MAX_ELEMENTS + 8) @(posedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/isd_pkg.sv
hdl/isd_if.sv
hdl/isd_cell.sv
hdl/insertion_sort_descending_unit.sv
tb/isd_order_checker.sv
tb/insertion_sort_descending_unit_tb.sv
